// ===== hw/rtl/dhlcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlcd_pkg
// Shared codes and types for the dual-half LCD dirty-byte refresh unit.
// ----------------------------------------------------------------------------
package dhlcd_pkg;

   // Item kinds carried on the request tuser field.
   typedef enum logic [1:0] {
      KIND_DRAW    = 2'd0,
      KIND_CLEAR   = 2'd1,
      KIND_REFRESH = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   localparam logic [7:0] CMD_SET_COLUMN = 8'h40;
   localparam logic [7:0] CMD_SET_PAGE   = 8'hB8;
   localparam logic [7:0] FILL_BLACK     = 8'hFF;
   localparam logic [7:0] FILL_WHITE     = 8'h00;
   localparam logic [7:0] PAGE_FIELD     = 8'h07;
   localparam logic [7:0] COLUMN_FIELD   = 8'h3F;

   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       is_command;
      logic       side;
   } rsp_entry_type;

   // Up to three bus bytes produced by one refresh step, in order.
   typedef struct packed {
      logic [1:0]                         count;
      rsp_entry_type [MAX_RESULTS-1:0]    entry;
   } rsp_batch_type;

endpackage

// ===== hw/rtl/dhlcd_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlcd_store
// Frame buffer and panel shadow memories, one write and one read port each,
// with registered read data.
// ----------------------------------------------------------------------------
module dhlcd_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        frame_rd,
   output logic [7:0]        shadow_rd,
   input  logic              frame_we,
   input  logic [ADDR_W-1:0] frame_waddr,
   input  logic [7:0]        frame_wdata,
   input  logic              shadow_we,
   input  logic [ADDR_W-1:0] shadow_waddr,
   input  logic [7:0]        shadow_wdata
);
   import dhlcd_pkg::*;

   logic [7:0] frame_mem  [DEPTH];
   logic [7:0] shadow_mem [DEPTH];
   logic [7:0] frame_rd_ff;
   logic [7:0] shadow_rd_ff;

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= frame_wdata;
      end
      if (shadow_we) begin
         shadow_mem[shadow_waddr] <= shadow_wdata;
      end
      if (rd_en) begin
         frame_rd_ff  <= frame_mem[rd_addr];
         shadow_rd_ff <= shadow_mem[rd_addr];
      end
   end

   assign frame_rd  = frame_rd_ff;
   assign shadow_rd = shadow_rd_ff;

endmodule

// ===== hw/rtl/dhlcd_rsp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlcd_rsp
// Result buffer: holds the bus bytes of one refresh step and hands them out
// one item per handshake.
// ----------------------------------------------------------------------------
module dhlcd_rsp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     batch_load,
   input  dhlcd_pkg::rsp_batch_type batch,
   output logic                     empty,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // side, bus_byte[7:0], zero pad
   output logic                     rsp_tuser,   // is_command
   output logic                     rsp_tlast
);
   import dhlcd_pkg::*;

   rsp_entry_type [MAX_RESULTS-1:0] ent_ff, ent_in;
   logic [1:0] head_ff, head_in;
   logic [1:0] rem_ff, rem_in;
   rsp_entry_type cur;

   assign cur        = ent_ff[head_ff];
   assign empty      = (rem_ff == 2'd0);
   assign rsp_tvalid = !empty;
   assign rsp_tdata  = {7'd0, cur.bus_byte, cur.side};
   assign rsp_tuser  = cur.is_command;
   assign rsp_tlast  = (rem_ff == 2'd1);

   always_comb begin
      ent_in  = ent_ff;
      head_in = head_ff;
      rem_in  = rem_ff;
      if (batch_load) begin
         ent_in  = batch.entry;
         head_in = 2'd0;
         rem_in  = batch.count;
      end else if (rsp_tvalid && rsp_tready) begin
         head_in = head_ff + 2'd1;
         rem_in  = rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 2'd0;
         rem_ff  <= 2'd0;
      end else begin
         head_ff <= head_in;
         rem_ff  <= rem_in;
      end
      ent_ff <= ent_in;
   end

endmodule

// ===== hw/rtl/dhlcd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlcd_ctrl
// Sequencer: read-modify-write of the frame and shadow memories, clearing
// sweeps, scan position and the bus byte sequence of each refresh step.
// ----------------------------------------------------------------------------
module dhlcd_ctrl #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 64,
   parameter int ADDR_W  = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_kind,
   input  logic [6:0]               req_pos_x,
   input  logic [5:0]               req_pos_y,
   input  logic                     req_ink,
   input  logic                     rsp_empty,
   output logic                     batch_load,
   output dhlcd_pkg::rsp_batch_type batch,
   output logic                     rd_en,
   output logic [ADDR_W-1:0]        rd_addr,
   input  logic [7:0]               frame_rd,
   input  logic [7:0]               shadow_rd,
   output logic                     frame_we,
   output logic [ADDR_W-1:0]        frame_waddr,
   output logic [7:0]               frame_wdata,
   output logic                     shadow_we,
   output logic [ADDR_W-1:0]        shadow_waddr,
   output logic [7:0]               shadow_wdata
);
   import dhlcd_pkg::*;

   localparam int PAGES  = ROWS / 8;
   localparam int HALF   = COLUMNS / 2;
   localparam int DEPTH  = PAGES * COLUMNS;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int EXP_W  = $clog2(COLUMNS + 1);

   typedef enum logic [2:0] {
      ST_SWEEP = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  sweep_addr_ff, sweep_addr_in;
   logic               sweep_both_ff, sweep_both_in;
   logic [7:0]         fill_ff, fill_in;
   logic               op_refresh_ff, op_refresh_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [2:0]         bit_ff, bit_in;
   logic               ink_ff, ink_in;
   logic [PAGE_W-1:0]  scan_page_ff, scan_page_in;
   logic [COL_W-1:0]   scan_col_ff, scan_col_in;
   logic [EXP_W-1:0]   exp_col_ff, exp_col_in;

   logic [8:0]         x_red;
   logic [7:0]         y_red;
   logic [ADDR_W-1:0]  draw_addr;
   logic [ADDR_W-1:0]  scan_addr;
   logic               accept;
   logic               pg_cmd, col_cmd, diff, side;
   logic [7:0]         draw_mask;
   rsp_batch_type      step_batch;
   logic [1:0]         n;

   // Coordinates wrap modulo the panel size; the narrow inputs need at most
   // eight subtract steps for the smallest panel.
   always_comb begin
      x_red = {2'b00, req_pos_x};
      y_red = {2'b00, req_pos_y};
      for (int i = 0; i < 8; i++) begin
         if (x_red >= 9'(COLUMNS)) begin
            x_red = x_red - 9'(COLUMNS);
         end
         if (y_red >= 8'(ROWS)) begin
            y_red = y_red - 8'(ROWS);
         end
      end
   end

   assign draw_addr = ADDR_W'(int'(y_red[7:3]) * COLUMNS + int'(x_red));
   assign scan_addr = ADDR_W'(int'(scan_page_ff) * COLUMNS + int'(scan_col_ff));
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign draw_mask = 8'd1 << bit_ff;

   // Bus bytes of a refresh step at the current scan position.
   assign pg_cmd  = (scan_col_ff == COL_W'(0)) || (scan_col_ff == COL_W'(HALF));
   assign diff    = (frame_rd != shadow_rd);
   assign col_cmd = diff && (pg_cmd || (exp_col_ff != EXP_W'(scan_col_ff)));
   assign side    = (scan_col_ff >= COL_W'(HALF));

   always_comb begin
      step_batch = '0;
      n = 2'd0;
      if (pg_cmd) begin
         step_batch.entry[n].side       = side;
         step_batch.entry[n].is_command = 1'b1;
         step_batch.entry[n].bus_byte   = CMD_SET_PAGE | (8'(scan_page_ff) & PAGE_FIELD);
         n = n + 2'd1;
      end
      if (col_cmd) begin
         step_batch.entry[n].side       = side;
         step_batch.entry[n].is_command = 1'b1;
         step_batch.entry[n].bus_byte   = CMD_SET_COLUMN | (8'(scan_col_ff) & COLUMN_FIELD);
         n = n + 2'd1;
      end
      if (diff) begin
         step_batch.entry[n].side       = side;
         step_batch.entry[n].is_command = 1'b0;
         step_batch.entry[n].bus_byte   = frame_rd;
         n = n + 2'd1;
      end
      step_batch.count = n;
   end

   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_both_in = sweep_both_ff;
      fill_in       = fill_ff;
      op_refresh_in = op_refresh_ff;
      addr_in       = addr_ff;
      bit_in        = bit_ff;
      ink_in        = ink_ff;
      scan_page_in  = scan_page_ff;
      scan_col_in   = scan_col_ff;
      exp_col_in    = exp_col_ff;
      rd_en         = 1'b0;
      rd_addr       = draw_addr;
      frame_we      = 1'b0;
      frame_waddr   = addr_ff;
      frame_wdata   = frame_rd;
      shadow_we     = 1'b0;
      shadow_waddr  = scan_addr;
      shadow_wdata  = frame_rd;
      batch_load    = 1'b0;
      batch         = step_batch;

      case (state_ff)
         ST_SWEEP: begin
            frame_we     = 1'b1;
            frame_waddr  = sweep_addr_ff;
            frame_wdata  = fill_ff;
            shadow_we    = sweep_both_ff;
            shadow_waddr = sweep_addr_ff;
            shadow_wdata = FILL_WHITE;
            if (sweep_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in      = ST_IDLE;
               sweep_both_in = 1'b0;
               sweep_addr_in = '0;
            end else begin
               sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_DRAW: begin
                     rd_en         = 1'b1;
                     rd_addr       = draw_addr;
                     addr_in       = draw_addr;
                     bit_in        = y_red[2:0];
                     ink_in        = req_ink;
                     op_refresh_in = 1'b0;
                     state_in      = ST_EXEC;
                  end
                  KIND_CLEAR: begin
                     fill_in       = req_ink ? FILL_BLACK : FILL_WHITE;
                     sweep_addr_in = '0;
                     state_in      = ST_SWEEP;
                  end
                  KIND_REFRESH: begin
                     rd_en         = 1'b1;
                     rd_addr       = scan_addr;
                     op_refresh_in = 1'b1;
                     state_in      = ST_EXEC;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_EXEC: begin
            if (!op_refresh_ff) begin
               frame_we    = 1'b1;
               frame_waddr = addr_ff;
               frame_wdata = ink_ff ? (frame_rd | draw_mask) : (frame_rd & ~draw_mask);
               state_in    = ST_IDLE;
            end else if (rsp_empty) begin
               // The previous step's bytes are gone, so this batch may load.
               batch_load = (step_batch.count != 2'd0);
               shadow_we  = diff;
               if (diff) begin
                  exp_col_in = EXP_W'(scan_col_ff) + EXP_W'(1);
               end else if (pg_cmd) begin
                  exp_col_in = EXP_W'(COLUMNS);
               end
               if (scan_col_ff == COL_W'(COLUMNS - 1)) begin
                  scan_col_in = '0;
                  if (scan_page_ff == PAGE_W'(PAGES - 1)) begin
                     scan_page_in = '0;
                  end else begin
                     scan_page_in = scan_page_ff + PAGE_W'(1);
                  end
               end else begin
                  scan_col_in = scan_col_ff + COL_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         sweep_both_ff <= 1'b1;
         fill_ff       <= FILL_WHITE;
         op_refresh_ff <= 1'b0;
         scan_page_ff  <= '0;
         scan_col_ff   <= '0;
         exp_col_ff    <= EXP_W'(COLUMNS);
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_both_ff <= sweep_both_in;
         fill_ff       <= fill_in;
         op_refresh_ff <= op_refresh_in;
         scan_page_ff  <= scan_page_in;
         scan_col_ff   <= scan_col_in;
         exp_col_ff    <= exp_col_in;
      end
      addr_ff <= addr_in;
      bit_ff  <= bit_in;
      ink_ff  <= ink_in;
   end

endmodule

// ===== hw/rtl/dual_half_lcd_dirty_refresh_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_half_lcd_dirty_refresh_unit
// Page-organized monochrome frame buffer with a panel shadow copy; refresh
// steps emit only the bus bytes needed to bring the panel up to date.
//
// Channel  Direction  tdata / tuser                              tlast
// req      in         tdata: pos_x, pos_y, ink; tuser: kind      -
// rsp      out        tdata: side, bus_byte; tuser: is_command   last result of item
//
// A draw or refresh item reads memory when accepted, then does the write back.
// A clear item sweeps the whole frame memory with its fill value.
// After reset a clearing pass zeroes both memories while req_tready stays low.
// A refresh item waits before its write back until the previous item's results
// have all been taken; draw and clear items proceed while results drain.
// ----------------------------------------------------------------------------
module dual_half_lcd_dirty_refresh_unit #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // pos_x[6:0], pos_y[5:0], ink, zero pad
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // side, bus_byte[7:0], zero pad
   output logic        rsp_tuser,   // is_command
   output logic        rsp_tlast
);
   import dhlcd_pkg::*;

   localparam int DEPTH  = (ROWS / 8) * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic              rsp_empty;
   logic              batch_load;
   rsp_batch_type     batch;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        frame_rd, shadow_rd;
   logic              frame_we, shadow_we;
   logic [ADDR_W-1:0] frame_waddr, shadow_waddr;
   logic [7:0]        frame_wdata, shadow_wdata;

   dhlcd_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .ADDR_W  (ADDR_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser),
      .req_pos_x    (req_tdata[6:0]),
      .req_pos_y    (req_tdata[12:7]),
      .req_ink      (req_tdata[13]),
      .rsp_empty    (rsp_empty),
      .batch_load   (batch_load),
      .batch        (batch),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .frame_rd     (frame_rd),
      .shadow_rd    (shadow_rd),
      .frame_we     (frame_we),
      .frame_waddr  (frame_waddr),
      .frame_wdata  (frame_wdata),
      .shadow_we    (shadow_we),
      .shadow_waddr (shadow_waddr),
      .shadow_wdata (shadow_wdata)
   );

   dhlcd_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock        (clock),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .frame_rd     (frame_rd),
      .shadow_rd    (shadow_rd),
      .frame_we     (frame_we),
      .frame_waddr  (frame_waddr),
      .frame_wdata  (frame_wdata),
      .shadow_we    (shadow_we),
      .shadow_waddr (shadow_waddr),
      .shadow_wdata (shadow_wdata)
   );

   dhlcd_rsp u_rsp (
      .clock      (clock),
      .reset      (reset),
      .batch_load (batch_load),
      .batch      (batch),
      .empty      (rsp_empty),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/dhlcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlcd_checker
// Port-level checks for the dual-half LCD dirty refresh unit.
// ----------------------------------------------------------------------------
module dhlcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   import dhlcd_pkg::*;

   // A held result item keeps its contents until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // Every accepted item of a known kind makes the block busy, so req_tready drops after acceptance.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != KIND_NONE) |=> !req_tready)
      else $error("item accepted on consecutive cycles");

   // Command bytes are either set-page or set-column codes.
   a_cmd_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[8:7] == 2'b01) || (rsp_tdata[8:4] == 5'b10111))
      else $error("malformed command byte");

   // A data byte always ends the results of its item.
   a_data_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("data byte not marked last");

   // Reset leaves no result pending and starts the clearing pass.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("block active right after reset");

endmodule

bind dual_half_lcd_dirty_refresh_unit dhlcd_checker u_dhlcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
